// ===== rtl/core/gqc_pkg.sv =====
// Shared codes for the glyph quad clipper: verdicts and register indexes.
package gqc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] VERDICT_DISCARD = 2'd0;
    localparam logic [1:0] VERDICT_CLIP    = 2'd1;
    localparam logic [1:0] VERDICT_WHOLE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_H = 3'd3;

endpackage

// ===== rtl/core/gqc_clip.sv =====
// First pipeline stage: per-axis clip against the box and quad verdict.
module gqc_clip #(
    parameter int C = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_vld,
    input  logic signed [C-1:0] qx,
    input  logic signed [C-1:0] qy,
    input  logic [C-2:0]        qw,
    input  logic [C-2:0]        qh,
    input  logic signed [C-1:0] box_x,
    input  logic signed [C-1:0] box_y,
    input  logic [C-2:0]        box_w,
    input  logic [C-2:0]        box_h,
    output logic                vld_reg,
    output logic [1:0]          verdict_reg,
    output logic [C-1:0]        cx_reg,
    output logic [C-1:0]        cy_reg,
    output logic [C-2:0]        cw_reg,
    output logic [C-2:0]        ch_reg,
    output logic [C-2:0]        offx_reg,
    output logic [C-2:0]        offy_reg
);

    localparam int D = C - 1;

    logic signed [C:0]   pmax_x, bmax_x, hi_x, span_x;
    logic signed [C:0]   pmax_y, bmax_y, hi_y, span_y;
    logic signed [C-1:0] lo_x, lo_y, cx, cy, offx, offy;
    logic                hit_x, hit_y;
    logic [D-1:0]        cw, ch;
    logic [1:0]          verdict;

    always_comb
    begin
        pmax_x = {qx[C-1], qx} + $signed({2'b00, qw});
        bmax_x = {box_x[C-1], box_x} + $signed({2'b00, box_w});
        lo_x   = (qx > box_x) ? qx : box_x;
        hi_x   = (pmax_x < bmax_x) ? pmax_x : bmax_x;
        hit_x  = $signed({lo_x[C-1], lo_x}) < hi_x;
        span_x = hi_x - $signed({lo_x[C-1], lo_x});
        cw     = hit_x ? span_x[D-1:0] : '0;
        cx     = hit_x ? lo_x : qx;
        offx   = cx - qx;

        pmax_y = {qy[C-1], qy} + $signed({2'b00, qh});
        bmax_y = {box_y[C-1], box_y} + $signed({2'b00, box_h});
        lo_y   = (qy > box_y) ? qy : box_y;
        hi_y   = (pmax_y < bmax_y) ? pmax_y : bmax_y;
        hit_y  = $signed({lo_y[C-1], lo_y}) < hi_y;
        span_y = hi_y - $signed({lo_y[C-1], lo_y});
        ch     = hit_y ? span_y[D-1:0] : '0;
        cy     = hit_y ? lo_y : qy;
        offy   = cy - qy;

        if (cw == qw && ch == qh)
        begin
            verdict = gqc_pkg::VERDICT_WHOLE;
        end
        else if (cw == '0 || ch == '0)
        begin
            verdict = gqc_pkg::VERDICT_DISCARD;
        end
        else
        begin
            verdict = gqc_pkg::VERDICT_CLIP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg <= verdict;
            cx_reg      <= cx;
            cy_reg      <= cy;
            cw_reg      <= cw;
            ch_reg      <= ch;
            offx_reg    <= offx[D-1:0];
            offy_reg    <= offy[D-1:0];
        end
    end

endmodule

// ===== rtl/core/gqc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module gqc_div #(
    parameter int C      = 16,
    parameter int L      = 4,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_vld,
    input  logic [2*C-2:0]    in_num [L],
    input  logic [C-2:0]      in_den [L],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [C-1:0]      out_q [L],
    output logic [SIDE_W-1:0] out_side
);

    localparam int D = C - 1;

    // quotient is known to fit C bits, so the top D dividend bits seed the remainder
    logic [D-1:0]      rem_reg  [1:C][L];
    logic [C-1:0]      low_reg  [1:C][L];
    logic [C-1:0]      q_reg    [1:C][L];
    logic [D-1:0]      den_reg  [1:C][L];
    logic [SIDE_W-1:0] side_reg [1:C];
    logic              vld_reg  [1:C];

    for (genvar k = 0; k < C; k++)
    begin : g_stage
        logic [D-1:0]      p_rem  [L];
        logic [C-1:0]      p_low  [L];
        logic [C-1:0]      p_q    [L];
        logic [D-1:0]      p_den  [L];
        logic [SIDE_W-1:0] p_side;
        logic              p_vld;

        if (k == 0)
        begin : g_first
            for (genvar l = 0; l < L; l++)
            begin : g_lane
                assign p_rem[l] = in_num[l][2*C-2:C];
                assign p_low[l] = in_num[l][C-1:0];
                assign p_q[l]   = '0;
                assign p_den[l] = in_den[l];
            end
            assign p_side = in_side;
            assign p_vld  = in_vld;
        end
        else
        begin : g_rest
            for (genvar l = 0; l < L; l++)
            begin : g_lane
                assign p_rem[l] = rem_reg[k][l];
                assign p_low[l] = low_reg[k][l];
                assign p_q[l]   = q_reg[k][l];
                assign p_den[l] = den_reg[k][l];
            end
            assign p_side = side_reg[k];
            assign p_vld  = vld_reg[k];
        end

        for (genvar l = 0; l < L; l++)
        begin : g_calc
            logic [D:0] trial;
            logic       ge;

            assign trial = {p_rem[l], p_low[l][C-1-k]};
            assign ge    = trial >= {1'b0, p_den[l]};

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[k+1][l] <= ge ? (trial[D-1:0] - p_den[l]) : trial[D-1:0];
                    low_reg[k+1][l] <= p_low[l];
                    q_reg[k+1][l]   <= {p_q[l][C-2:0], ge};
                    den_reg[k+1][l] <= p_den[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k+1] <= p_side;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k+1] <= p_vld;
            end
        end
    end

    for (genvar l = 0; l < L; l++)
    begin : g_out
        assign out_q[l] = q_reg[C][l];
    end
    assign out_side = side_reg[C];
    assign out_vld  = vld_reg[C];

endmodule

// ===== rtl/core/glyph_quad_clip_uv_remap.sv =====
// Top level of the glyph quad clipper with texture coordinate remap.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_axis  | in        | s_tvalid/s_tready  | s_tdata: quad and texture rectangle
//  m_axis  | out       | m_tvalid/m_tready  | m_tdata: result rectangle, m_tuser: verdict
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data: clip box registers
//
// One quad per cycle sustained while the output is not stalled. The stages are the clip stage,
// multiply stage, COORD_BITS divider stages (one quotient bit each) and output stage.
// The divider pipeline takes a new dividend each cycle unless the pipeline is stalled.
// The whole pipeline advances together whenever the output register is empty or
// taken; a stall holds every stage, so nothing is lost or repeated.
// Reset clears valid bits and loads the box to origin 0,0 with maximum size.
module glyph_quad_clip_uv_remap #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // quad_x, quad_y, quad_w, quad_h, tex_x, tex_y, tex_w, tex_h, zero pad
    input  logic [((8*COORD_BITS-2)+7)/8*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_w, out_h, out_tex_x, out_tex_y, out_tex_w, out_tex_h, zero pad
    output logic [((8*COORD_BITS-2)+7)/8*8-1:0] m_tdata,
    // verdict
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gqc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]          cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int D      = C - 1;
    localparam int PAY_W  = 8 * C - 2;
    localparam int BUS_W  = (PAY_W + 7) / 8 * 8;
    localparam int L      = 4;
    localparam int SIDE_W = 2 + 2 * C + 2 * D + PAY_W;

    // field offsets inside the payload
    localparam int O_QX = 0;
    localparam int O_QY = C;
    localparam int O_QW = 2 * C;
    localparam int O_QH = 2 * C + D;
    localparam int O_TX = 2 * C + 2 * D;
    localparam int O_TY = O_TX + C;
    localparam int O_TW = O_TX + 2 * C;
    localparam int O_TH = O_TX + 3 * C;

    logic advance;

    // ---------------- clip box registers ----------------
    logic signed [C-1:0] box_x_reg, box_y_reg;
    logic [D-1:0]        box_w_reg, box_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= '0;
            box_y_reg <= '0;
            box_w_reg <= '1;
            box_h_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gqc_pkg::CFG_BOX_X: box_x_reg <= cfg_data;
                gqc_pkg::CFG_BOX_Y: box_y_reg <= cfg_data;
                gqc_pkg::CFG_BOX_W: box_w_reg <= cfg_data[D-1:0];
                gqc_pkg::CFG_BOX_H: box_h_reg <= cfg_data[D-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: clip ----------------
    logic               c_vld;
    logic [1:0]         c_verdict;
    logic [C-1:0]       c_cx, c_cy;
    logic [D-1:0]       c_cw, c_ch, c_offx, c_offy;
    logic [PAY_W-1:0]   raw1_reg;

    gqc_clip #(.C(C)) u_clip (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_vld      (s_tvalid),
        .qx          (s_tdata[O_QX +: C]),
        .qy          (s_tdata[O_QY +: C]),
        .qw          (s_tdata[O_QW +: D]),
        .qh          (s_tdata[O_QH +: D]),
        .box_x       (box_x_reg),
        .box_y       (box_y_reg),
        .box_w       (box_w_reg),
        .box_h       (box_h_reg),
        .vld_reg     (c_vld),
        .verdict_reg (c_verdict),
        .cx_reg      (c_cx),
        .cy_reg      (c_cy),
        .cw_reg      (c_cw),
        .ch_reg      (c_ch),
        .offx_reg    (c_offx),
        .offy_reg    (c_offy)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw1_reg <= s_tdata[PAY_W-1:0];
        end
    end

    // ---------------- stage 2: products ----------------
    logic                m_vld_reg;
    logic [2*C-2:0]      prod_reg [L];
    logic [D-1:0]        den_reg  [L];
    logic [SIDE_W-1:0]   side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg[0] <= c_offx * raw1_reg[O_TW +: C];
            prod_reg[1] <= c_cw   * raw1_reg[O_TW +: C];
            prod_reg[2] <= c_offy * raw1_reg[O_TH +: C];
            prod_reg[3] <= c_ch   * raw1_reg[O_TH +: C];
            den_reg[0]  <= raw1_reg[O_QW +: D];
            den_reg[1]  <= raw1_reg[O_QW +: D];
            den_reg[2]  <= raw1_reg[O_QH +: D];
            den_reg[3]  <= raw1_reg[O_QH +: D];
            side2_reg   <= {c_verdict, c_cx, c_cy, c_cw, c_ch, raw1_reg};
        end
    end

    // ---------------- divider stages ----------------
    logic              d_vld;
    logic [C-1:0]      d_q [L];
    logic [SIDE_W-1:0] d_side;

    gqc_div #(.C(C), .L(L), .SIDE_W(SIDE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (m_vld_reg),
        .in_num   (prod_reg),
        .in_den   (den_reg),
        .in_side  (side2_reg),
        .out_vld  (d_vld),
        .out_q    (d_q),
        .out_side (d_side)
    );

    // ---------------- output stage ----------------
    logic [1:0]       f_verdict;
    logic [C-1:0]     f_cx, f_cy;
    logic [D-1:0]     f_cw, f_ch;
    logic [PAY_W-1:0] f_raw;
    logic [C:0]       sum_x, sum_y;
    logic [PAY_W-1:0] result;

    assign {f_verdict, f_cx, f_cy, f_cw, f_ch, f_raw} = d_side;

    always_comb
    begin
        sum_x = {1'b0, f_raw[O_TX +: C]} + {1'b0, d_q[0]};
        sum_y = {1'b0, f_raw[O_TY +: C]} + {1'b0, d_q[2]};
        case (f_verdict)
            gqc_pkg::VERDICT_WHOLE:
            begin
                result = f_raw;
            end
            gqc_pkg::VERDICT_CLIP:
            begin
                // texture start saturates at the top of its range
                result = {d_q[3], d_q[1],
                          sum_y[C] ? {C{1'b1}} : sum_y[C-1:0],
                          sum_x[C] ? {C{1'b1}} : sum_x[C-1:0],
                          f_ch, f_cw, f_cy, f_cx};
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    logic             ovld_reg;
    logic [PAY_W-1:0] odata_reg;
    logic [1:0]       overdict_reg;

    assign advance = !ovld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (advance)
        begin
            ovld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            odata_reg    <= result;
            overdict_reg <= (f_verdict == gqc_pkg::VERDICT_CLIP ||
                             f_verdict == gqc_pkg::VERDICT_WHOLE) ?
                            f_verdict : gqc_pkg::VERDICT_DISCARD;
        end
    end

    assign s_tready = advance;
    assign m_tvalid = ovld_reg;
    assign m_tdata  = {{(BUS_W - PAY_W){1'b0}}, odata_reg};
    assign m_tuser  = overdict_reg;

endmodule

// ===== rtl/core/gqc_checker.sv =====
// Port-level assertions for the glyph quad clipper, bound to the top level.
module gqc_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((8*COORD_BITS-2)+7)/8*8-1:0]    m_tdata,
    input logic [1:0]                             m_tuser
);

    localparam int C = COORD_BITS;

    // held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an empty output register never refuses input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused while output empty");

    // discarded quads carry an all-zero rectangle
    a_discard: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == gqc_pkg::VERDICT_DISCARD |-> m_tdata == '0)
        else $error("discarded result not zero");

    // a clipped quad has positive size on both axes
    a_clip_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == gqc_pkg::VERDICT_CLIP |->
            m_tdata[3*C-2:2*C] != '0 && m_tdata[4*C-3:3*C-1] != '0)
        else $error("clipped result with zero size");

endmodule

bind glyph_quad_clip_uv_remap gqc_checker #(.COORD_BITS(COORD_BITS)) u_gqc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the glyph quad clipper: directed and random quads against a clip predictor.
module testbench;

    localparam int CB = 16;
    localparam int DW = ((8*CB-2)+7)/8*8;   // 128-bit bus: 126 bits of packed quad fields plus zero pad
    localparam int LAT = CB + 3;            // pipeline depth from the port list header
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [15:0] tex_h;
        logic [15:0] tex_w;
        logic [15:0] tex_y;
        logic [15:0] tex_x;
        logic [14:0] qh;
        logic [14:0] qw;
        logic [15:0] qy;
        logic [15:0] qx;
    } quad_t;

    typedef struct {
        logic [1:0]   verdict;
        logic [DW-1:0] data;
    } clip_res_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [DW-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [gqc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CB-1:0] cfg_data = '0;

    glyph_quad_clip_uv_remap #(.COORD_BITS(CB)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // predictor's copy of the clip box
    longint bx, by, bw, bh;

    quad_t     quad_q[$];       // quads waiting to be sent
    clip_res_t expected_q[$];   // predicted results, oldest first
    int errors = 0;
    int mismatches = 0;
    longint cycles = 0;
    logic in_fire = 0;          // input transaction taken at the last rising edge

    function automatic void add_quad(input quad_t q);
        quad_q.insert(quad_q.size(), q);
    endfunction

    // Clip one axis: start p, length len against box b, blen.
    function automatic void clip_span(input longint p, input longint len, input longint b,
                                      input longint blen, output longint cmin,
                                      output longint csize);
        longint lo, hi;
        lo = (p > b) ? p : b;
        hi = ((p + len) < (b + blen)) ? (p + len) : (b + blen);
        if (lo < hi) begin
            cmin = lo;
            csize = hi - lo;
        end
        else begin
            cmin = p;
            csize = 0;
        end
    endfunction

    function automatic longint remap_tex(input longint t, input longint off,
                                         input longint tl, input longint len);
        longint r;
        r = t + (off * tl) / len;
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic clip_res_t predict_clip(input quad_t q);
        clip_res_t r;
        quad_t o;
        longint qx, qy, qw, qh, cx, cy, cw, ch;
        qx = longint'($signed(q.qx));
        qy = longint'($signed(q.qy));
        qw = q.qw;
        qh = q.qh;
        clip_span(qx, qw, bx, bw, cx, cw);
        clip_span(qy, qh, by, bh, cy, ch);
        r.data = '0;
        if (cw == qw && ch == qh) begin
            r.verdict = gqc_pkg::VERDICT_WHOLE;
            r.data[$bits(quad_t)-1:0] = q;
        end
        else if (cw == 0 || ch == 0) begin
            r.verdict = gqc_pkg::VERDICT_DISCARD;
        end
        else begin
            r.verdict = gqc_pkg::VERDICT_CLIP;
            o.qx = cx[15:0];
            o.qy = cy[15:0];
            o.qw = cw[14:0];
            o.qh = ch[14:0];
            o.tex_x = 16'(remap_tex(q.tex_x, cx - qx, q.tex_w, qw));
            o.tex_y = 16'(remap_tex(q.tex_y, cy - qy, q.tex_h, qh));
            o.tex_w = 16'((cw * q.tex_w) / qw);
            o.tex_h = 16'((ch * q.tex_h) / qh);
            r.data[$bits(quad_t)-1:0] = o;
        end
        return r;
    endfunction

    // Input transactions are seen at the rising edge where they happen.
    always @(posedge clk) begin
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready) begin
            expected_q.insert(expected_q.size(),
                              predict_clip(quad_t'(s_tdata[$bits(quad_t)-1:0])));
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || in_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 0;
                end
                else if (quad_q.size() > 0) begin
                    s_tdata <= {{(DW-$bits(quad_t)){1'b0}}, quad_q.pop_front()};
                    s_tvalid <= 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                    end
                end
                else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Receiver: stall pattern switches mode every so often, including no-stall stretches.
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0: m_tready <= 1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk) begin
        clip_res_t want;
        if (rst_n) begin
            cycles++;
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    if (mismatches < 10) $display("unexpected result %h", m_tdata);
                    mismatches++;
                end
                else begin
                    want = expected_q.pop_front();
                    if (want.verdict !== m_tuser || want.data !== m_tdata) begin
                        errors++;
                        if (mismatches < 10)
                            $display("mismatch: verdict exp %0d got %0d, data exp %h got %h",
                                     want.verdict, m_tuser, want.data, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (cycles > LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [gqc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CB-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        case (idx)
            gqc_pkg::CFG_BOX_X: bx = longint'($signed(val));
            gqc_pkg::CFG_BOX_Y: by = longint'($signed(val));
            gqc_pkg::CFG_BOX_W: bw = val[14:0];
            default:            bh = val[14:0];
        endcase
    endtask

    task automatic set_box(input logic [15:0] x, input logic [15:0] y,
                           input logic [14:0] w, input logic [14:0] h);
        write_reg(gqc_pkg::CFG_BOX_X, x);
        write_reg(gqc_pkg::CFG_BOX_Y, y);
        write_reg(gqc_pkg::CFG_BOX_W, {1'b0, w});
        write_reg(gqc_pkg::CFG_BOX_H, {1'b0, h});
    endtask

    // Let every queued quad go through and the pipeline drain.
    task automatic drain;
        while (quad_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    function automatic quad_t rand_quad();
        quad_t q;
        q = quad_t'({$urandom, $urandom, $urandom, $urandom});
        return q;
    endfunction

    // Quads near the box so clipping, whole and discard cases all occur.
    function automatic quad_t near_quad();
        quad_t q;
        int span;
        q = rand_quad();
        span = (bw > 64) ? 64 : int'(bw) + 8;
        q.qx = 16'(bx + $signed($urandom_range(0, 2*span + 40)) - 40);
        q.qy = 16'(by + $signed($urandom_range(0, 2*span + 40)) - 40);
        if ($urandom_range(0, 3) != 0) begin
            q.qw = 15'($urandom_range(0, 80));
            q.qh = 15'($urandom_range(0, 80));
        end
        return q;
    endfunction

    initial begin
        quad_t q;
        bx = 0; by = 0; bw = 32767; bh = 32767;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: default box, extremes of every field.
        q = '0; add_quad(q);
        q = '1; add_quad(q);
        q = '0; q.qw = 15'h7fff; q.qh = 15'h7fff; q.tex_w = 16'hffff; q.tex_h = 16'hffff;
        add_quad(q);
        q.qx = 16'h8000; q.qy = 16'h8000; add_quad(q);   // lies wholly left of and above the box: discard
        q.qx = 16'h7fff; q.qy = 16'h7fff; add_quad(q);
        drain();

        set_box(16'd100, 16'd200, 15'd50, 15'd40);
        q = '0; q.qx = 16'd110; q.qy = 16'd210; q.qw = 15'd10; q.qh = 15'd10;
        q.tex_x = 16'd5;
        add_quad(q);                                         // wholly inside
        q.qx = 16'd90; q.qw = 15'd20; q.tex_w = 16'hffff; q.tex_x = 16'hfff0;
        add_quad(q);                                         // clipped, texture saturates
        q.qx = 16'd0; q.qw = 15'd10; add_quad(q);            // disjoint: discard
        q.qx = 16'd150; add_quad(q);                         // touching right edge: discard
        q.qx = 16'd110; q.qw = 15'd0; add_quad(q);           // zero width inside: whole
        q.qy = 16'd0; add_quad(q);                           // zero width, y outside: discard
        q.qx = 16'd80; q.qy = 16'd190; q.qw = 15'd100; q.qh = 15'd100;
        q.tex_w = 16'd333; q.tex_h = 16'd77;
        add_quad(q);                                         // clipped on all sides
        drain();

        set_box(16'h8000, 16'h8000, 15'd0, 15'h7fff);         // zero-width box
        q = rand_quad(); add_quad(q);
        q.qw = 15'd0; q.qh = 15'd0; add_quad(q);
        drain();

        // Random phases across several boxes.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: set_box(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
                1: set_box(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                           15'($urandom_range(1, 120)), 15'($urandom_range(1, 120)));
                2: set_box(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
                default: set_box(16'h8000, 16'($urandom), 15'h7fff, 15'($urandom_range(0, 64)));
            endcase
            for (int i = 0; i < 160; i++) begin
                add_quad(($urandom_range(0, 3) == 0) ? rand_quad() : near_quad());
            end
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
